// File: rtl/double_ended_queue_defines.svh
// assertion macros for the double-ended queue rtl, used by deq_back
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef SYNTH
`define DEQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/deq_pkg.sv
// types and constants shared by the double-ended queue modules
package deq_pkg;
	localparam int DATA_W = 32;
	localparam int CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 3;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_DUMP
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		BK_CMD,
		BK_DUMP
	} bk_state_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] entry_value;
		status_t                  status;
		logic                     last;
	} result_t;
endpackage

// File: rtl/deq_front.sv
// input side: takes items and decodes the command into an operation
module deq_front (
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [deq_pkg::CMD_W-1:0]          s_tuser,
	input  logic signed [deq_pkg::DATA_W-1:0]  s_tdata,
	input  logic                               q_full,
	output logic                               enq,
	output deq_pkg::cmd_item_t                 enq_item
);
	logic known;

	always_comb begin
		known = 1'b1;
		enq_item.op = deq_pkg::OP_PUSH_FRONT;
		enq_item.value = s_tdata;
		unique case (s_tuser)
			deq_pkg::CMD_PUSH_FRONT: enq_item.op = deq_pkg::OP_PUSH_FRONT;
			deq_pkg::CMD_PUSH_BACK:  enq_item.op = deq_pkg::OP_PUSH_BACK;
			deq_pkg::CMD_POP_FRONT:  enq_item.op = deq_pkg::OP_POP_FRONT;
			deq_pkg::CMD_POP_BACK:   enq_item.op = deq_pkg::OP_POP_BACK;
			deq_pkg::CMD_DUMP:       enq_item.op = deq_pkg::OP_DUMP;
			default:                 known = 1'b0;
		endcase
	end

	// unknown commands are taken and dropped here
	assign s_tready = !q_full;
	assign enq = s_tvalid && !q_full && known;
endmodule

// File: rtl/deq_cmdq.sv
// short command queue between the decode side and the execute side
module deq_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  deq_pkg::cmd_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output deq_pkg::cmd_item_t head
);
	localparam int PTR_W = $clog2(deq_pkg::CMDQ_DEPTH);
	localparam int CNT_W = $clog2(deq_pkg::CMDQ_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(deq_pkg::CMDQ_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(deq_pkg::CMDQ_DEPTH);

	deq_pkg::cmd_item_t slot_q [deq_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == FULL_CNT;
	assign not_empty = cnt_q != '0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// File: rtl/deq_back.sv
// execute side: ring store, front index and count, dump sequencer, result queue
`include "double_ended_queue_defines.svh"
module deq_back #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  deq_pkg::cmd_item_t q_item,
	output logic               q_pop,
	output logic               m_valid,
	input  logic               m_ready,
	output deq_pkg::result_t   m_item
);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
	localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(DEPTH);
	localparam int OQ_PTR_W = $clog2(deq_pkg::OUTQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(deq_pkg::OUTQ_DEPTH + 1);
	localparam logic [OQ_PTR_W-1:0] OQ_LAST = OQ_PTR_W'(deq_pkg::OUTQ_DEPTH - 1);
	localparam logic [OQ_CNT_W-1:0] OQ_FULL = OQ_CNT_W'(deq_pkg::OUTQ_DEPTH);
	localparam logic [OQ_CNT_W:0] OQ_LIMIT = (OQ_CNT_W + 1)'(deq_pkg::OUTQ_DEPTH);

	deq_pkg::bk_state_t state_q, state_next;

	logic [deq_pkg::DATA_W-1:0] ring_q [DEPTH];
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] dump_addr_q;
	logic [CNT_W-1:0] dump_left_q;

	logic                  valid_s1;
	deq_pkg::status_t      status_s1;
	logic                  last_s1;
	logic                  is_mem_s1;
	logic [deq_pkg::DATA_W-1:0] rd_data_s1;

	deq_pkg::result_t      oq_q [deq_pkg::OUTQ_DEPTH];
	logic [OQ_PTR_W-1:0]   oq_wr_q;
	logic [OQ_PTR_W-1:0]   oq_rd_q;
	logic [OQ_CNT_W-1:0]   oq_cnt_q;

	logic             full;
	logic             empty;
	logic             room;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] dump_addr_inc;
	logic [IDX_W:0]   back_sum;
	logic [IDX_W-1:0] back_idx;

	logic             issue;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	deq_pkg::status_t res_status;
	logic             res_last;
	logic             oq_pop;
	deq_pkg::result_t oq_entry;

	assign full = count_q == FULL_CNT;
	assign empty = count_q == '0;
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign dump_addr_inc = (dump_addr_q == LAST_IDX) ? '0 : dump_addr_q + 1'b1;
	// front plus count stays below twice the depth, one subtract wraps it
	assign back_sum = (IDX_W + 1)'(front_q) + (IDX_W + 1)'(count_q);
	assign back_idx = (back_sum >= DEPTH_W) ? IDX_W'(back_sum - DEPTH_W) : IDX_W'(back_sum);
	// result queue slots not yet spoken for, counting the one in flight
	assign room = ((OQ_CNT_W + 1)'(oq_cnt_q) + (OQ_CNT_W + 1)'(valid_s1)) < OQ_LIMIT;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			deq_pkg::BK_CMD: begin
				if (issue && q_item.op == deq_pkg::OP_DUMP && !empty && count_q != ONE_CNT) begin
					state_next = deq_pkg::BK_DUMP;
				end
			end
			deq_pkg::BK_DUMP: begin
				if (issue && dump_left_q == ONE_CNT) begin
					state_next = deq_pkg::BK_CMD;
				end
			end
			default: state_next = deq_pkg::BK_CMD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		issue = 1'b0;
		q_pop = 1'b0;
		wr_en = 1'b0;
		wr_addr = back_idx;
		rd_en = 1'b0;
		rd_addr = front_q;
		res_status = deq_pkg::ST_OK;
		res_last = 1'b1;
		unique case (state_q)
			deq_pkg::BK_CMD: begin
				if (q_valid && room) begin
					issue = 1'b1;
					q_pop = 1'b1;
					unique case (q_item.op)
						deq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								res_status = deq_pkg::ST_FULL;
							end else begin
								wr_en = 1'b1;
								wr_addr = front_dec;
							end
						end
						deq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								res_status = deq_pkg::ST_FULL;
							end else begin
								wr_en = 1'b1;
							end
						end
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
							if (empty) begin
								res_status = deq_pkg::ST_EMPTY;
							end
						end
						deq_pkg::OP_DUMP: begin
							if (empty) begin
								res_status = deq_pkg::ST_EMPTY;
							end else begin
								rd_en = 1'b1;
								res_last = count_q == ONE_CNT;
							end
						end
						default: ;
					endcase
				end
			end
			deq_pkg::BK_DUMP: begin
				if (room) begin
					issue = 1'b1;
					rd_en = 1'b1;
					rd_addr = dump_addr_q;
					res_last = dump_left_q == ONE_CNT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_q[wr_addr] <= q_item.value;
		end
		if (rd_en) begin
			rd_data_s1 <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::BK_CMD;
			front_q <= '0;
			count_q <= '0;
			dump_addr_q <= '0;
			dump_left_q <= '0;
		end else begin
			state_q <= state_next;
			if (issue && state_q == deq_pkg::BK_CMD) begin
				unique case (q_item.op)
					deq_pkg::OP_PUSH_FRONT: begin
						if (!full) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end
					end
					deq_pkg::OP_PUSH_BACK: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					deq_pkg::OP_POP_FRONT: begin
						if (!empty) begin
							front_q <= front_inc;
							count_q <= count_q - 1'b1;
						end
					end
					deq_pkg::OP_POP_BACK: begin
						if (!empty) begin
							count_q <= count_q - 1'b1;
						end
					end
					deq_pkg::OP_DUMP: begin
						dump_addr_q <= front_inc;
						dump_left_q <= count_q - 1'b1;
					end
					default: ;
				endcase
			end else if (issue) begin
				dump_addr_q <= dump_addr_inc;
				dump_left_q <= dump_left_q - 1'b1;
			end
		end
	end

	// stage 1 waits for the ring read data
	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= res_status;
			last_s1 <= res_last;
			is_mem_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	// result queue
	assign oq_entry.entry_value = is_mem_s1 ? rd_data_s1 : '0;
	assign oq_entry.status = status_s1;
	assign oq_entry.last = last_s1;
	assign m_valid = oq_cnt_q != '0;
	assign m_item = oq_q[oq_rd_q];
	assign oq_pop = m_valid && m_ready;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wr_q] <= oq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_wr_q <= (oq_wr_q == OQ_LAST) ? '0 : oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_LAST) ? '0 : oq_rd_q + 1'b1;
			end
			unique case ({valid_s1, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	`DEQ_ASSERT(a_oq_no_overflow, valid_s1 |-> oq_cnt_q != OQ_FULL, "result queue overflow")
	`DEQ_ASSERT_ALWAYS(a_count_range, !arst_n || count_q <= FULL_CNT, "entry count beyond depth")
	`DEQ_ASSERT(a_dump_left, state_q == deq_pkg::BK_DUMP |-> dump_left_q != '0 && dump_left_q < count_q, "dump counter out of range")
	`DEQ_ASSERT(a_push_counts, issue && wr_en |=> count_q == $past(count_q) + 1'b1, "push did not grow the count")
endmodule

// File: rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries. A push at
// either end, a pop at either end or a status-only answer needs no extra sequencer state,
// so such commands flow at one item per cycle while the result queue has room; a dump
// reads the stored entries in turn through the single read port of the ring store and
// gives one result per stored entry, with tlast on the final one. Pushes, pops and a dump
// of an empty queue give exactly one result with tlast set. A command is decoded on entry
// and waits in a two-entry command queue; with both queues empty its first result passes
// through the command queue, the read stage and the result queue before it is offered. A
// three-entry result queue decouples the output from the execute side. Unknown command
// codes are taken and produce no result. The store needs no clearing after reset.
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic signed [deq_pkg::DATA_W-1:0]  s_tdata,  // value
	input  logic [deq_pkg::CMD_W-1:0]          s_tuser,  // cmd
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [deq_pkg::DATA_W-1:0]  m_tdata,  // entry_value
	output logic [1:0]                         m_tuser,  // status
	output logic                               m_tlast
);
	logic               q_full;
	logic               enq;
	deq_pkg::cmd_item_t enq_item;
	logic               q_pop;
	logic               q_valid;
	deq_pkg::cmd_item_t q_head;
	deq_pkg::result_t   res;

	deq_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.enq      (enq),
		.enq_item (enq_item)
	);

	deq_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (enq),
		.push_item (enq_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	deq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_head),
		.q_pop   (q_pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_item  (res)
	);

	assign m_tdata = res.entry_value;
	assign m_tuser = res.status;
	assign m_tlast = res.last;
endmodule

// File: sim/double_ended_queue_tb.sv
// self-checking testbench for the double-ended queue: directed table, then random command sequences
module double_ended_queue_tb;
	localparam int DEPTH = 16;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 8;
	localparam int TOTAL_ITEMS = 430;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int DRAIN_CYCLES = 30;

	typedef logic [deq_pkg::CMD_W-1:0] cmd_code_t;

	// codes the block takes but answers with nothing
	localparam cmd_code_t CMD_SPARE_5 = 3'd5;
	localparam cmd_code_t CMD_SPARE_6 = 3'd6;
	localparam cmd_code_t CMD_SPARE_7 = 3'd7;

	typedef struct {
		cmd_code_t                         cmd;
		logic signed [deq_pkg::DATA_W-1:0] value;
		int                                reps;
		bit                                rnd;
		bit                                typed;
		deq_pkg::status_t                  st;
	} stim_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic signed [deq_pkg::DATA_W-1:0] s_tdata = '0;
	cmd_code_t                         s_tuser = deq_pkg::CMD_PUSH_FRONT;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic signed [deq_pkg::DATA_W-1:0] m_tdata;
	logic [1:0]                        m_tuser;
	logic                              m_tlast;

	// shadow of the ring store
	logic signed [deq_pkg::DATA_W-1:0] ring_store [DEPTH];
	int unsigned                       ring_head = 0;
	int unsigned                       ring_fill = 0;

	deq_pkg::result_t staged_answers[$];
	deq_pkg::result_t awaited_answers[$];

	int  items_sent = 0;
	int  spare_sent = 0;
	int  refused_pushes = 0;
	int  empty_answers = 0;
	int  dump_entries = 0;
	int  results_checked = 0;
	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  burst_left = 4;
	bit  hold_req = 1'b0;

	stim_row_t directed_rows [15] = '{
		'{CMD_SPARE_5,             -1,            1,         1'b0, 1'b0, deq_pkg::ST_OK},
		'{CMD_SPARE_7,             32'sh7fffffff, 1,         1'b0, 1'b0, deq_pkg::ST_OK},
		// a single entry popped from the front leaves nothing to dump
		'{deq_pkg::CMD_PUSH_BACK,  42,            1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_POP_FRONT,  0,             1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_DUMP,       0,             1,         1'b0, 1'b1, deq_pkg::ST_EMPTY},
		// same from the back, then both pops on empty
		'{deq_pkg::CMD_PUSH_FRONT, 7,             1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_POP_BACK,   0,             1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_POP_BACK,   0,             1,         1'b0, 1'b1, deq_pkg::ST_EMPTY},
		'{deq_pkg::CMD_POP_FRONT,  -1,            1,         1'b0, 1'b1, deq_pkg::ST_EMPTY},
		'{deq_pkg::CMD_PUSH_FRONT, 32'sh7fffffff, 1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_PUSH_BACK,  32'sh80000000, 1,         1'b0, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_DUMP,       0,             1,         1'b0, 1'b0, deq_pkg::ST_OK},
		'{deq_pkg::CMD_PUSH_BACK,  0,             DEPTH - 2, 1'b1, 1'b1, deq_pkg::ST_OK},
		'{deq_pkg::CMD_PUSH_FRONT, -1,            1,         1'b0, 1'b1, deq_pkg::ST_FULL},
		'{deq_pkg::CMD_PUSH_BACK,  32'sh80000000, 1,         1'b0, 1'b1, deq_pkg::ST_FULL}
	};

	double_ended_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),    // value
		.s_tuser(s_tuser),    // cmd
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),    // entry_value
		.m_tuser(m_tuser),    // status
		.m_tlast(m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic deq_pkg::result_t make_answer(logic signed [deq_pkg::DATA_W-1:0] v,
			deq_pkg::status_t st, logic lst);
		deq_pkg::result_t r;
		r.entry_value = v;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function automatic void predict_deque_answer(cmd_code_t cmd,
			logic signed [deq_pkg::DATA_W-1:0] val);
		staged_answers.delete();
		case (cmd)
			deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					staged_answers.push_back(make_answer('0, deq_pkg::ST_FULL, 1'b1));
					refused_pushes++;
				end else begin
					if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
						ring_head = (ring_head + DEPTH - 1) % DEPTH;
						ring_store[ring_head] = val;
					end else begin
						ring_store[(ring_head + ring_fill) % DEPTH] = val;
					end
					ring_fill++;
					staged_answers.push_back(make_answer('0, deq_pkg::ST_OK, 1'b1));
				end
			end
			deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
				if (ring_fill == 0) begin
					staged_answers.push_back(make_answer('0, deq_pkg::ST_EMPTY, 1'b1));
					empty_answers++;
				end else begin
					if (cmd == deq_pkg::CMD_POP_FRONT)
						ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
					staged_answers.push_back(make_answer('0, deq_pkg::ST_OK, 1'b1));
				end
			end
			deq_pkg::CMD_DUMP: begin
				if (ring_fill == 0) begin
					staged_answers.push_back(make_answer('0, deq_pkg::ST_EMPTY, 1'b1));
					empty_answers++;
				end else begin
					for (int i = 0; i < ring_fill; i++)
						staged_answers.push_back(make_answer(ring_store[(ring_head + i) % DEPTH],
							deq_pkg::ST_OK, i == ring_fill - 1));
					dump_entries += ring_fill;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [deq_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// bursts of random length, sometimes long, with short gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
	endtask

	task automatic offer_item(cmd_code_t cmd, logic signed [deq_pkg::DATA_W-1:0] val,
			bit typed, deq_pkg::status_t st);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		predict_deque_answer(cmd, val);
		if (typed)
			awaited_answers.push_back(make_answer('0, st, 1'b1));
		else
			foreach (staged_answers[k])
				awaited_answers.push_back(staged_answers[k]);
		if (cmd <= deq_pkg::CMD_DUMP)
			items_sent++;
		else
			spare_sent++;
		pace_sender();
	endtask

	task automatic idle_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	// receiver: its own stall pattern, plus one long hold on request
	initial begin
		int mode;
		int mode_left;
		mode = 0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ~m_tready;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		deq_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (awaited_answers.size() == 0) begin
				$error("result with nothing awaited: entry_value %0d status %0d last %0b",
					m_tdata, m_tuser, m_tlast);
				mismatches++;
			end else begin
				want = awaited_answers.pop_front();
				if (m_tdata !== want.entry_value) begin
					$error("entry_value: expected %0d, got %0d", want.entry_value, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					mismatches++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles where neither side moves an item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int n;
		bit hold_done;
		bit pause_done;
		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			repeat (directed_rows[r].reps)
				offer_item(directed_rows[r].cmd,
					directed_rows[r].rnd ? rand_value() : directed_rows[r].value,
					directed_rows[r].typed, directed_rows[r].st);

		while (items_sent < TOTAL_ITEMS) begin
			if (!hold_done && items_sent >= 150) begin
				// output held off while pushes keep coming, so the input backs up
				hold_done = 1'b1;
				hold_req = 1'b1;
				repeat (DEPTH + 2)
					offer_item($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT
						: deq_pkg::CMD_PUSH_BACK, rand_value(), 1'b0, deq_pkg::ST_OK);
			end
			if (!pause_done && items_sent >= 300) begin
				pause_done = 1'b1;
				idle_until_drained();
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, DEPTH - ring_fill + 2);
					repeat (n)
						offer_item($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT
							: deq_pkg::CMD_PUSH_BACK, rand_value(), 1'b0, deq_pkg::ST_OK);
				end
				3, 4: begin
					n = $urandom_range(1, ring_fill + 2);
					repeat (n)
						offer_item($urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT
							: deq_pkg::CMD_POP_BACK, rand_value(), 1'b0, deq_pkg::ST_OK);
				end
				5: offer_item(deq_pkg::CMD_DUMP, rand_value(), 1'b0, deq_pkg::ST_OK);
				6, 7, 8: begin
					n = $urandom_range(1, 8);
					repeat (n)
						offer_item(cmd_code_t'($urandom_range(deq_pkg::CMD_PUSH_FRONT,
							deq_pkg::CMD_DUMP)), rand_value(), 1'b0, deq_pkg::ST_OK);
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n)
						offer_item(cmd_code_t'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)),
							$urandom, 1'b0, deq_pkg::ST_OK);
				end
			endcase
		end

		idle_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d commands and %0d unused codes; checked %0d results, %0d dump entries",
			items_sent, spare_sent, results_checked, dump_entries);
		$display("%0d pushes refused when full, %0d answers on empty, %0d mismatches",
			refused_pushes, empty_answers, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
